@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ design/tsc_pkg.sv @@
// ---------------------------------------------------------------------------
// tsc_pkg
// formats, angle constants and reciprocal tables for the sine/cosine unit
// ---------------------------------------------------------------------------
package tsc_pkg;

  localparam int DATA_W       = 32;
  localparam int FRAC_BITS    = 28;
  localparam int WORK_BITS    = 58;
  localparam int WORK_W       = 64;
  localparam int ANG_W        = DATA_W + 2;
  localparam int SHIFT        = WORK_BITS - FRAC_BITS;
  localparam int SERIES_TERMS = 7;
  localparam int MAX_TERMS    = 12;
  localparam int IDX_W        = $clog2(MAX_TERMS);

  // pi and 2pi with 60 fraction bits
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611B;

  // rounded to the angle format
  localparam logic [63:0] PI_FX =
    (PI_Q60 >> (60 - FRAC_BITS)) + ((PI_Q60 >> (59 - FRAC_BITS)) & 64'd1);
  localparam logic [63:0] TWO_PI_FX =
    (TWO_PI_Q60 >> (60 - FRAC_BITS)) + ((TWO_PI_Q60 >> (59 - FRAC_BITS)) & 64'd1);
  localparam logic signed [ANG_W-1:0] PI_F     = ANG_W'(PI_FX);
  localparam logic signed [ANG_W-1:0] TWO_PI_F = ANG_W'(TWO_PI_FX);

  localparam logic [WORK_W-1:0] ONE_W = WORK_W'(1) << WORK_BITS;

  typedef logic [WORK_W-1:0] recip_tab_t [MAX_TERMS];

  // round(1 / ((2i+2)(2i+3))) in the work format, for table index i
  localparam recip_tab_t RECIP_SIN = '{
    (ONE_W + 64'd3)   / 64'd6,
    (ONE_W + 64'd10)  / 64'd20,
    (ONE_W + 64'd21)  / 64'd42,
    (ONE_W + 64'd36)  / 64'd72,
    (ONE_W + 64'd55)  / 64'd110,
    (ONE_W + 64'd78)  / 64'd156,
    (ONE_W + 64'd105) / 64'd210,
    (ONE_W + 64'd136) / 64'd272,
    (ONE_W + 64'd171) / 64'd342,
    (ONE_W + 64'd210) / 64'd420,
    (ONE_W + 64'd253) / 64'd506,
    (ONE_W + 64'd300) / 64'd600
  };

  // round(1 / ((2i+1)(2i+2))) in the work format, for table index i
  localparam recip_tab_t RECIP_COS = '{
    (ONE_W + 64'd1)   / 64'd2,
    (ONE_W + 64'd6)   / 64'd12,
    (ONE_W + 64'd15)  / 64'd30,
    (ONE_W + 64'd28)  / 64'd56,
    (ONE_W + 64'd45)  / 64'd90,
    (ONE_W + 64'd66)  / 64'd132,
    (ONE_W + 64'd91)  / 64'd182,
    (ONE_W + 64'd120) / 64'd240,
    (ONE_W + 64'd153) / 64'd306,
    (ONE_W + 64'd190) / 64'd380,
    (ONE_W + 64'd231) / 64'd462,
    (ONE_W + 64'd276) / 64'd552
  };

  function automatic logic [WORK_W-1:0] recip(input logic cosine,
                                              input logic [IDX_W-1:0] idx);
    return cosine ? RECIP_COS[idx] : RECIP_SIN[idx];
  endfunction

endpackage

@@ design/tsc_mul.sv @@
// ---------------------------------------------------------------------------
// tsc_mul
// pipelined signed 64x64 fixed-point multiply with optional negation, rounded and saturated to the work format
// ---------------------------------------------------------------------------
module tsc_mul #(
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [tsc_pkg::WORK_W-1:0]  a,
  input  logic signed [tsc_pkg::WORK_W-1:0]  b,
  input  logic                               negate,
  input  logic        [SIDE_W-1:0]           side_in,
  output logic                               out_valid,
  output logic signed [tsc_pkg::WORK_W-1:0]  p,
  output logic        [SIDE_W-1:0]           side_out
);
  import tsc_pkg::*;

  localparam int STAGES = 5;
  localparam int HALF   = WORK_W / 2;
  localparam int SH     = WORK_W - WORK_BITS;
  localparam logic [WORK_W-1:0] MAG_MAX = {1'b0, {(WORK_W-1){1'b1}}};

  logic [STAGES-1:0] vld;
  logic [SIDE_W-1:0] side_q [STAGES];

  logic [WORK_W-1:0] ua, ub;
  logic              sg1, sg2, sg3, sg4;
  logic [WORK_W-1:0] p00, p01, p10, p11;
  logic [HALF+1:0]   mid;
  logic [WORK_W-1:0] hip;
  logic [WORK_W-1:0] r;
  logic [WORK_W-1:0] r_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign r_sat = r[WORK_W-1] ? MAG_MAX : r;

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and product sign
      ua  <= a[WORK_W-1] ? WORK_W'(-a) : WORK_W'(a);
      ub  <= b[WORK_W-1] ? WORK_W'(-b) : WORK_W'(b);
      sg1 <= a[WORK_W-1] ^ b[WORK_W-1] ^ negate;
      // four half-width partial products
      p00 <= WORK_W'(ua[HALF-1:0])      * WORK_W'(ub[HALF-1:0]);
      p01 <= WORK_W'(ua[HALF-1:0])      * WORK_W'(ub[WORK_W-1:HALF]);
      p10 <= WORK_W'(ua[WORK_W-1:HALF]) * WORK_W'(ub[HALF-1:0]);
      p11 <= WORK_W'(ua[WORK_W-1:HALF]) * WORK_W'(ub[WORK_W-1:HALF]);
      sg2 <= sg1;
      // middle column and upper word without the middle carry
      mid <= (HALF+2)'(p00[WORK_W-1:HALF]) + (HALF+2)'(p01[HALF-1:0])
           + (HALF+2)'(p10[HALF-1:0]);
      hip <= p11 + WORK_W'(p01[WORK_W-1:HALF]) + WORK_W'(p10[WORK_W-1:HALF]);
      sg3 <= sg2;
      // product bits above the work point, plus the round bit
      r   <= {hip[WORK_BITS-1:0], mid[HALF-1:HALF-SH]}
           + WORK_W'({mid[HALF+1:HALF], {SH{1'b0}}})
           + WORK_W'(mid[HALF-SH-1]);
      sg4 <= sg3;
      p   <= sg4 ? -signed'(r_sat) : signed'(r_sat);
    end
  end

  assign out_valid = vld[STAGES-1];
  assign side_out  = side_q[STAGES-1];

endmodule

@@ design/taylor_sine_cosine_unit.sv @@
// ---------------------------------------------------------------------------
// taylor_sine_cosine_unit: Taylor sine/cosine, one angle per unstalled cycle
// the pipeline is built as a chain of 5-stage multipliers
// one transaction per unstalled cycle; a 2-entry output buffer decouples stalls
// synchronous active-high reset clears all valid bits and the output buffer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module taylor_sine_cosine_unit #(
  parameter int SERIES_TERMS = tsc_pkg::SERIES_TERMS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic signed [tsc_pkg::DATA_W-1:0]   s_tdata,   // angle
  input  logic                                s_tuser,   // mode (0 sine, 1 cosine)
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic signed [tsc_pkg::DATA_W-1:0]   m_tdata    // value
);
  import tsc_pkg::*;

  localparam int RND_W = DATA_W + 3;
  localparam logic signed [WORK_W-1:0] PI_X = WORK_W'(PI_F) <<< SHIFT;
  localparam logic [RND_W-1:0] LIM_POS = RND_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [RND_W-1:0] LIM_NEG = RND_W'(1) << (DATA_W - 1);

  logic en;

  // input register
  logic                     iv;
  logic signed [DATA_W-1:0] iang;
  logic                     imode;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (en) begin
      iv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iang  <= s_tdata;
      imode <= s_tuser;
    end
  end

  // range reduction: one 2pi step covers the whole input range
  logic signed [ANG_W-1:0] a_ext, a_sub, a_add, a_red;

  assign a_ext = ANG_W'(iang);
  assign a_sub = a_ext - TWO_PI_F;
  assign a_add = a_ext + TWO_PI_F;

  always_comb begin
    if (a_ext > PI_F) begin
      a_red = a_sub;
    end else if (a_ext < -PI_F) begin
      a_red = a_add;
    end else begin
      a_red = a_ext;
    end
  end

  logic                     rv;
  logic signed [WORK_W-1:0] rx;
  logic                     rmode;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (en) begin
      rv <= iv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx    <= WORK_W'(a_red) <<< SHIFT;
      rmode <= imode;
    end
  end

  // x squared, carrying mode and the first term
  logic signed [WORK_W-1:0] term0;
  logic                     x2v;
  logic signed [WORK_W-1:0] x2;
  logic [WORK_W:0]          x2side;

  assign term0 = rmode ? signed'(ONE_W) : rx;

  tsc_mul #(.SIDE_W(WORK_W + 1)) u_mul_x2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (rv),
    .a        (rx),
    .b        (rx),
    .negate   (1'b0),
    .side_in  ({rmode, term0}),
    .out_valid(x2v),
    .p        (x2),
    .side_out (x2side)
  );

  // first factor x^2 / d1
  logic                     y1v;
  logic signed [WORK_W-1:0] y1;
  logic [2*WORK_W:0]        y1side;

  tsc_mul #(.SIDE_W(2*WORK_W + 1)) u_mul_y1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (x2v),
    .a        (x2),
    .b        (signed'(recip(x2side[WORK_W], IDX_W'(0)))),
    .negate   (1'b0),
    .side_in  ({x2, x2side}),
    .out_valid(y1v),
    .p        (y1),
    .side_out (y1side)
  );

  // per-term stage registers; index k feeds term k+1
  logic                     sv    [SERIES_TERMS+1];
  logic signed [WORK_W-1:0] ssum  [SERIES_TERMS+1];
  logic signed [WORK_W-1:0] sterm [SERIES_TERMS];
  logic signed [WORK_W-1:0] sy    [SERIES_TERMS];
  logic signed [WORK_W-1:0] sx2   [SERIES_TERMS];
  logic                     smode [SERIES_TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= y1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx2[0]   <= y1side[2*WORK_W:WORK_W+1];
      smode[0] <= y1side[WORK_W];
      sterm[0] <= y1side[WORK_W-1:0];
      ssum[0]  <= y1side[WORK_W-1:0];
      sy[0]    <= y1;
    end
  end

  for (genvar i = 1; i <= SERIES_TERMS; i++) begin : g_term
    logic                     tv;
    logic signed [WORK_W-1:0] tp;
    logic signed [WORK_W-1:0] tsum;

    // term_i = -(term_{i-1} * y_i)
    tsc_mul #(.SIDE_W(WORK_W)) u_mul_t (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sv[i-1]),
      .a        (sterm[i-1]),
      .b        (sy[i-1]),
      .negate   (1'b1),
      .side_in  (ssum[i-1]),
      .out_valid(tv),
      .p        (tp),
      .side_out (tsum)
    );

    if (i < SERIES_TERMS) begin : g_next
      logic                     yv;
      logic signed [WORK_W-1:0] yp;
      logic [WORK_W:0]          yside;

      // next factor computed alongside this term
      tsc_mul #(.SIDE_W(WORK_W + 1)) u_mul_y (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .in_valid (sv[i-1]),
        .a        (sx2[i-1]),
        .b        (signed'(recip(smode[i-1], IDX_W'(i)))),
        .negate   (1'b0),
        .side_in  ({smode[i-1], sx2[i-1]}),
        .out_valid(yv),
        .p        (yp),
        .side_out (yside)
      );

      always_ff @(posedge clk) begin
        if (rst) begin
          sv[i] <= 1'b0;
        end else if (en) begin
          sv[i] <= tv & yv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ssum[i]  <= tsum + tp;
          sterm[i] <= tp;
          sy[i]    <= yp;
          sx2[i]   <= yside[WORK_W-1:0];
          smode[i] <= yside[WORK_W];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (rst) begin
          sv[i] <= 1'b0;
        end else if (en) begin
          sv[i] <= tv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ssum[i] <= tsum + tp;
        end
      end
    end
  end

  // back to the output format: magnitude, then round and clamp
  logic              fv;
  logic              fneg;
  logic [WORK_W-1:0] fm;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= sv[SERIES_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fneg <= ssum[SERIES_TERMS][WORK_W-1];
      fm   <= ssum[SERIES_TERMS][WORK_W-1] ? WORK_W'(-ssum[SERIES_TERMS])
                                            : WORK_W'(ssum[SERIES_TERMS]);
    end
  end

  logic [RND_W-1:0]  rr, lim, mm;
  logic [DATA_W-1:0] val;

  assign rr  = RND_W'(fm >> SHIFT) + RND_W'(fm[SHIFT-1]);
  assign lim = fneg ? LIM_NEG : LIM_POS;
  assign mm  = (rr > lim) ? lim : rr;
  assign val = fneg ? -mm[DATA_W-1:0] : mm[DATA_W-1:0];

  // two-entry output buffer
  logic [DATA_W-1:0] ob [2];
  logic [1:0]        cnt;
  logic              push, pop;

  assign pop      = m_tvalid & m_tready;
  assign push     = en & fv;
  assign en       = (cnt != 2'd2) | m_tready;
  assign s_tready = en;
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = signed'(ob[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        ob[0] <= val;
      end else begin
        ob[0] <= ob[1];
        ob[1] <= val;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        ob[0] <= val;
      end else begin
        ob[1] <= val;
      end
    end else if (pop) begin
      ob[0] <= ob[1];
    end
  end

  `ASSERT_PROP(a_reduced_range, clk, rst, (rv |-> ((rx <= PI_X) && (rx >= -PI_X))))
  `ASSERT_PROP(a_sum_bounded, clk, rst, (fv |-> (fm < (ONE_W << 1))))
  `ASSERT_NEVER(a_buf_overflow, clk, rst, (push && !pop && (cnt == 2'd2)))
  `ASSERT_PROP(a_buf_fill, clk, rst, ((push && !pop) |=> (cnt == $past(cnt) + 2'd1)))
  `ASSERT_PROP(a_buf_drain, clk, rst, ((pop && !push) |=> (cnt == $past(cnt) - 2'd1)))

endmodule
